// File: rtl/srm_pkg.sv
// Shared constants, codes and types of the sensor running-average monitor.
`timescale 1ns / 1ps

package srm_pkg;

    localparam int MAX_SENSORS = 16;
    localparam int WINDOW_LEN  = 8;

    localparam int IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNT_W   = $clog2(MAX_SENSORS + 1);
    localparam int POS_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WCNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int WIN_DEPTH = MAX_SENSORS * WINDOW_LEN;
    localparam int WIN_AW  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int SUM_W   = 17 + $clog2(WINDOW_LEN);

    localparam logic signed [15:0] EMPTY_SAMPLE = -16'sd4800;
    localparam logic signed [15:0] VALID_FLOOR  = -16'sd4400;
    localparam logic signed [15:0] MAX_TEMP_RST = 16'sd400;
    localparam logic signed [15:0] MIN_TEMP_RST = 16'sd160;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_SAMPLE   = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_NORMAL     = 3'd0,
        ST_HOT        = 3'd1,
        ST_COLD       = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_FULL       = 3'd4,
        ST_REGISTERED = 3'd5,
        ST_CLEARED    = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        CFG_MAX_TEMP = 1'b0,
        CFG_MIN_TEMP = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [31:0]      last_time;
        logic [15:0]      room;
        logic [15:0]      id;
    } entry_t;

endpackage

// File: rtl/srm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module srm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/sensor_running_average_monitor_core.sv
// Top level of the sensor running-average monitor: sensor table, window memory, control.
//
//  channel | direction | transfer
//  s_*     | in        | s_tvalid & s_tready: op in tuser, sensor/room/time/temperature in tdata
//  m_*     | out       | m_tvalid & m_tready: status in tuser, sensor/room/average in tdata
//  cfg_*   | in        | cfg_we: threshold write at cfg_index
//
// Register: fills the new window, one window word a cycle; skipped with a full table.
// Sample hit on entry k: id scan up to k, window sum, shift divide, compare.
//   Unknown id: the scan checks every entry, none if the table is empty. Clear: no scan or fill.
// Reset empties the table through the fill count alone; no clearing pass.
// A result waits in the output register while the next item is taken; the block
// holds its last step until that register is free.
`timescale 1ns / 1ps

module sensor_running_average_monitor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // sensor_id, room_id, sample_time, temperature
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_sensor_id, out_room_id, average
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FILL   = 8'b0000_0010,
        S_SEARCH = 8'b0000_0100,
        S_UPDATE = 8'b0000_1000,
        S_SUM    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_RES    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] max_temp_reg, min_temp_reg;
    logic [srm_pkg::CNT_W-1:0]  cnt_reg;
    logic [srm_pkg::IDX_W-1:0]  scan_reg, chk_reg, idx_reg;
    logic                       chk_vld_reg;
    logic [srm_pkg::POS_W-1:0]  fill_reg, pos_reg;
    logic [srm_pkg::WCNT_W-1:0] rd_cnt_reg;
    logic                       acc_vld_reg;
    logic                       m_tvalid_reg;

    logic [15:0]               sid_reg, room_reg;
    logic [31:0]               time_reg;
    logic signed [15:0]        temp_reg;
    logic signed [srm_pkg::SUM_W-1:0] sum_reg;
    logic [srm_pkg::SUM_W-1:0] dv_reg;
    logic                      neg_reg;
    srm_pkg::status_t          res_status_reg;
    logic [15:0]               res_sid_reg, res_room_reg, res_avg_reg;
    logic [47:0]               m_tdata_reg;
    logic [2:0]                m_tuser_reg;

    srm_pkg::entry_t            ent_wdata, ent_rdata;
    logic                       ent_we;
    logic [srm_pkg::IDX_W-1:0]  ent_waddr;
    logic                       win_we;
    logic [srm_pkg::WIN_AW-1:0] win_waddr, win_raddr;
    logic [15:0]                win_wdata, win_rdata;

    srm_pkg::op_t       in_op;
    logic               accept;
    logic               table_full;
    logic               last_fill;
    logic               id_hit;
    logic               last_chk;
    logic [srm_pkg::IDX_W-1:0] scan_inc;
    logic [srm_pkg::POS_W-1:0] new_pos;
    logic [srm_pkg::WIN_AW-1:0] slot_base, idx_base;
    logic signed [15:0]        avg_val;
    logic                      out_free;
    logic signed [15:0]        win_sample;

    assign in_op      = srm_pkg::op_t'(s_tuser);
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign table_full = (cnt_reg >= srm_pkg::CNT_W'(srm_pkg::MAX_SENSORS));
    assign last_fill  = (fill_reg == srm_pkg::POS_W'(srm_pkg::WINDOW_LEN - 1));
    assign id_hit     = chk_vld_reg && (ent_rdata.id == sid_reg);
    assign last_chk   = chk_vld_reg && ((srm_pkg::CNT_W'(chk_reg) + 1'b1) == cnt_reg);
    assign scan_inc   = (scan_reg == srm_pkg::IDX_W'(srm_pkg::MAX_SENSORS - 1)) ?
                        '0 : scan_reg + 1'b1;
    assign new_pos    = (pos_reg == srm_pkg::POS_W'(srm_pkg::WINDOW_LEN - 1)) ?
                        '0 : pos_reg + 1'b1;
    assign slot_base  = srm_pkg::WIN_AW'(cnt_reg) * srm_pkg::WIN_AW'(srm_pkg::WINDOW_LEN);
    assign idx_base   = srm_pkg::WIN_AW'(idx_reg) * srm_pkg::WIN_AW'(srm_pkg::WINDOW_LEN);
    assign avg_val    = neg_reg ? 16'(~dv_reg + 1'b1) : 16'(dv_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign win_sample = win_rdata;

    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = idx_reg;
        ent_wdata = '{pos: new_pos, last_time: time_reg, room: room_reg, id: sid_reg};
        win_we    = 1'b0;
        win_waddr = idx_base + srm_pkg::WIN_AW'(new_pos);
        win_wdata = temp_reg;
        win_raddr = idx_base + srm_pkg::WIN_AW'(rd_cnt_reg[srm_pkg::POS_W-1:0]);
        case (state_reg)
            S_IDLE:
            begin
                ent_we    = accept && (in_op == srm_pkg::OP_REGISTER) && !table_full;
                ent_waddr = srm_pkg::IDX_W'(cnt_reg);
                ent_wdata = '{pos: '0, last_time: '0, room: s_tdata[31:16],
                              id: s_tdata[15:0]};
            end
            S_FILL:
            begin
                win_we    = 1'b1;
                win_waddr = slot_base + srm_pkg::WIN_AW'(fill_reg);
                win_wdata = srm_pkg::EMPTY_SAMPLE;
            end
            S_UPDATE:
            begin
                ent_we = 1'b1;
                win_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        srm_pkg::OP_REGISTER: state_next = table_full ? S_DONE : S_FILL;
                        srm_pkg::OP_SAMPLE:   state_next = (cnt_reg == '0) ? S_DONE : S_SEARCH;
                        srm_pkg::OP_CLEAR:    state_next = S_DONE;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_FILL:   state_next = last_fill ? S_DONE : S_FILL;
            S_SEARCH:
            begin
                if (id_hit)
                begin
                    state_next = S_UPDATE;
                end
                else if (last_chk)
                begin
                    state_next = S_DONE;
                end
            end
            S_UPDATE: state_next = S_SUM;
            S_SUM:
            begin
                if ((rd_cnt_reg == srm_pkg::WCNT_W'(srm_pkg::WINDOW_LEN)) && !acc_vld_reg)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:    state_next = S_RES;
            S_RES:    state_next = S_DONE;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            max_temp_reg <= srm_pkg::MAX_TEMP_RST;
            min_temp_reg <= srm_pkg::MIN_TEMP_RST;
            cnt_reg      <= '0;
            scan_reg     <= '0;
            chk_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            idx_reg      <= '0;
            fill_reg     <= '0;
            rd_cnt_reg   <= '0;
            acc_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (srm_pkg::cfg_idx_t'(cfg_index))
                    srm_pkg::CFG_MAX_TEMP: max_temp_reg <= cfg_wdata;
                    srm_pkg::CFG_MIN_TEMP: min_temp_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    fill_reg    <= '0;
                    scan_reg    <= '0;
                    chk_vld_reg <= 1'b0;
                    if (accept && (in_op == srm_pkg::OP_CLEAR))
                    begin
                        cnt_reg <= '0;
                    end
                end
                S_FILL:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    if (last_fill)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SEARCH:
                begin
                    scan_reg    <= scan_inc;
                    chk_reg     <= scan_reg;
                    chk_vld_reg <= 1'b1;
                    if (id_hit)
                    begin
                        idx_reg <= chk_reg;
                    end
                end
                S_UPDATE:
                begin
                    rd_cnt_reg  <= '0;
                    acc_vld_reg <= 1'b0;
                end
                S_SUM:
                begin
                    if (rd_cnt_reg != srm_pkg::WCNT_W'(srm_pkg::WINDOW_LEN))
                    begin
                        rd_cnt_reg  <= rd_cnt_reg + 1'b1;
                        acc_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_vld_reg <= 1'b0;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if ((state_reg != S_DONE) && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sid_reg      <= s_tdata[15:0];
                    room_reg     <= s_tdata[31:16];
                    time_reg     <= s_tdata[63:32];
                    temp_reg     <= s_tdata[79:64];
                    res_sid_reg  <= s_tdata[15:0];
                    res_room_reg <= '0;
                    res_avg_reg  <= '0;
                    case (in_op)
                        srm_pkg::OP_REGISTER:
                        begin
                            res_status_reg <= table_full ? srm_pkg::ST_FULL :
                                              srm_pkg::ST_REGISTERED;
                            if (!table_full)
                            begin
                                res_room_reg <= s_tdata[31:16];
                            end
                        end
                        srm_pkg::OP_SAMPLE: res_status_reg <= srm_pkg::ST_UNKNOWN;
                        default:
                        begin
                            res_status_reg <= srm_pkg::ST_CLEARED;
                            res_sid_reg    <= '0;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (id_hit)
                begin
                    room_reg     <= ent_rdata.room;
                    pos_reg      <= ent_rdata.pos;
                    res_room_reg <= ent_rdata.room;
                end
            end
            S_UPDATE:
            begin
                sum_reg <= '0;
            end
            S_SUM:
            begin
                if (acc_vld_reg && (win_sample > srm_pkg::VALID_FLOOR))
                begin
                    sum_reg <= sum_reg + srm_pkg::SUM_W'(win_sample);
                end
                neg_reg <= sum_reg[srm_pkg::SUM_W-1];
                dv_reg  <= sum_reg[srm_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
            end
            S_DIV:
            begin
                dv_reg <= dv_reg / srm_pkg::SUM_W'(srm_pkg::WINDOW_LEN);
            end
            S_RES:
            begin
                res_avg_reg <= avg_val;
                if (avg_val > max_temp_reg)
                begin
                    res_status_reg <= srm_pkg::ST_HOT;
                end
                else if (avg_val < min_temp_reg)
                begin
                    res_status_reg <= srm_pkg::ST_COLD;
                end
                else
                begin
                    res_status_reg <= srm_pkg::ST_NORMAL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {res_avg_reg, res_room_reg, res_sid_reg};
                    m_tuser_reg <= res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    srm_ram #(
        .WIDTH ($bits(srm_pkg::entry_t)),
        .DEPTH (srm_pkg::MAX_SENSORS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (scan_reg),
        .rdata (ent_rdata)
    );

    srm_ram #(
        .WIDTH (16),
        .DEPTH (srm_pkg::WIN_DEPTH)
    ) u_window_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

endmodule
